### rtl/pac_pkg.sv
// Shared types and constants for the PID angle controller.
`timescale 1ns / 1ps
package pac_pkg;

    localparam int CfgIdxW = 3;
    localparam int CfgDataW = 16;

    localparam logic [CfgIdxW-1:0] CfgTarget = 3'd0;
    localparam logic [CfgIdxW-1:0] CfgKp     = 3'd1;
    localparam logic [CfgIdxW-1:0] CfgKi     = 3'd2;
    localparam logic [CfgIdxW-1:0] CfgKd     = 3'd3;
    localparam logic [CfgIdxW-1:0] CfgIlim   = 3'd4;

    localparam logic [14:0] IlimReset = 15'd32767;

    typedef struct packed {
        logic signed [15:0] target;
        logic signed [15:0] kp;
        logic signed [15:0] ki;
        logic signed [15:0] kd;
        logic [14:0]        ilim;
    } t_cfg;

    typedef struct packed {
        logic mul_load;
        logic out_load;
    } t_back_ctl;

endpackage

### rtl/pac_cfg_regs.sv
// Configuration register file for the PID angle controller.
`timescale 1ns / 1ps
module pac_cfg_regs (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_we,
    input  logic [pac_pkg::CfgIdxW-1:0]       i_index,
    input  logic [pac_pkg::CfgDataW-1:0]      i_data,
    output pac_pkg::t_cfg                     o_cfg
);
    import pac_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.target <= '0;
            r_cfg.kp     <= '0;
            r_cfg.ki     <= '0;
            r_cfg.kd     <= '0;
            r_cfg.ilim   <= IlimReset;
        end else if (i_we) begin
            unique case (i_index)
                CfgTarget: r_cfg.target <= $signed(i_data);
                CfgKp:     r_cfg.kp     <= $signed(i_data);
                CfgKi:     r_cfg.ki     <= $signed(i_data);
                CfgKd:     r_cfg.kd     <= $signed(i_data);
                CfgIlim:   r_cfg.ilim   <= i_data[14:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

### rtl/pac_front.sv
// Error stage: saturated error, saturating error sum and error difference.
`timescale 1ns / 1ps
module pac_front #(
    parameter int DATA_WIDTH = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_load,
    input  logic signed [15:0]           i_meas,
    input  logic signed [15:0]           i_target,
    output logic signed [DATA_WIDTH-1:0] o_err,
    output logic signed [31:0]           o_sum,
    output logic signed [DATA_WIDTH:0]   o_delta
);
    import pac_pkg::*;

    localparam logic signed [33:0] ErrHi = (34'sd1 <<< (DATA_WIDTH - 1)) - 34'sd1;
    localparam logic signed [33:0] ErrLo = -ErrHi - 34'sd1;
    localparam logic signed [33:0] SumHi = 34'sd2147483647;
    localparam logic signed [33:0] SumLo = -SumHi - 34'sd1;

    logic signed [DATA_WIDTH-1:0] r_last_error;
    logic signed [31:0]           r_error_sum;
    logic signed [DATA_WIDTH:0]   r_delta;

    logic signed [33:0]           diff;
    logic signed [DATA_WIDTH-1:0] n_last_error;
    logic signed [33:0]           sum_wide;
    logic signed [31:0]           n_error_sum;
    logic signed [DATA_WIDTH:0]   n_delta;

    always_comb begin
        diff = 34'(i_target) - 34'(i_meas);
        priority if (diff > ErrHi) begin
            n_last_error = ErrHi[DATA_WIDTH-1:0];
        end else if (diff < ErrLo) begin
            n_last_error = ErrLo[DATA_WIDTH-1:0];
        end else begin
            n_last_error = diff[DATA_WIDTH-1:0];
        end

        sum_wide = 34'(r_error_sum) + 34'(n_last_error);
        priority if (sum_wide > SumHi) begin
            n_error_sum = SumHi[31:0];
        end else if (sum_wide < SumLo) begin
            n_error_sum = SumLo[31:0];
        end else begin
            n_error_sum = sum_wide[31:0];
        end

        n_delta = (DATA_WIDTH + 1)'(r_last_error) - (DATA_WIDTH + 1)'(n_last_error);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_error <= '0;
            r_error_sum  <= '0;
        end else if (i_load) begin
            r_last_error <= n_last_error;
            r_error_sum  <= n_error_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_delta <= n_delta;
        end
    end

    assign o_err   = r_last_error;
    assign o_sum   = r_error_sum;
    assign o_delta = r_delta;

endmodule

### rtl/pac_back.sv
// Gain products, integral clamp and saturated output sum.
`timescale 1ns / 1ps
module pac_back #(
    parameter int DATA_WIDTH = 16,
    parameter int FRAC_BITS  = 8
) (
    input  logic                         i_clk,
    input  pac_pkg::t_back_ctl           i_ctl,
    input  pac_pkg::t_cfg                i_cfg,
    input  logic signed [DATA_WIDTH-1:0] i_err,
    input  logic signed [31:0]           i_sum,
    input  logic signed [DATA_WIDTH:0]   i_delta,
    output logic signed [15:0]           o_drive_output,
    output logic                         o_integral_clamped
);
    import pac_pkg::*;

    localparam int PW = DATA_WIDTH + 16;
    localparam int IW = 48;
    localparam int DW = DATA_WIDTH + 17;
    localparam int TW = DATA_WIDTH + 19;
    localparam logic signed [TW-1:0] OutHi = (TW'(1) <<< (DATA_WIDTH - 1)) - TW'(1);
    localparam logic signed [TW-1:0] OutLo = -OutHi - TW'(1);

    logic signed [PW-1:0] r_p_prod;
    logic signed [IW-1:0] r_i_prod;
    logic signed [DW-1:0] r_d_prod;
    logic signed [15:0]   r_drive;
    logic                 r_clamped;

    logic signed [PW-1:0] p_term;
    logic signed [IW-1:0] i_raw;
    logic signed [IW-1:0] lim_pos;
    logic signed [IW-1:0] lim_neg;
    logic signed [15:0]   i_term;
    logic signed [DW-1:0] d_term;
    logic signed [TW-1:0] total;
    logic signed [TW-1:0] total_sat;
    logic                 n_clamped;

    always_ff @(posedge i_clk) begin
        if (i_ctl.mul_load) begin
            r_p_prod <= PW'(i_err) * PW'(i_cfg.kp);
            r_i_prod <= IW'(i_sum) * IW'(i_cfg.ki);
            r_d_prod <= DW'(i_delta) * DW'(i_cfg.kd);
        end
    end

    always_comb begin
        p_term  = r_p_prod >>> FRAC_BITS;
        i_raw   = r_i_prod >>> FRAC_BITS;
        d_term  = r_d_prod >>> FRAC_BITS;
        lim_pos = $signed({{(IW - 15){1'b0}}, i_cfg.ilim});
        lim_neg = -lim_pos;
        priority if (i_raw > lim_pos) begin
            i_term    = lim_pos[15:0];
            n_clamped = 1'b1;
        end else if (i_raw < lim_neg) begin
            i_term    = lim_neg[15:0];
            n_clamped = 1'b1;
        end else begin
            i_term    = i_raw[15:0];
            n_clamped = 1'b0;
        end

        total = TW'(p_term) + TW'(i_term) + TW'(d_term);
        priority if (total > OutHi) begin
            total_sat = OutHi;
        end else if (total < OutLo) begin
            total_sat = OutLo;
        end else begin
            total_sat = total;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.out_load) begin
            r_drive   <= total_sat[15:0];
            r_clamped <= n_clamped;
        end
    end

    assign o_drive_output     = r_drive;
    assign o_integral_clamped = r_clamped;

endmodule

### rtl/pid_angle_controller.sv
// PID angle controller with clamped integral term: top level.
// Throughput: one beat per cycle unless the output stalls, through a four-register
// pipeline (input, error, product and result registers); stages with bubbles fill
// while the output stalls.
// Reset: synchronous, active low; clears valids, error sum and last error,
// gains and target to zero and the integral limit to its maximum.
`timescale 1ns / 1ps
module pid_angle_controller #(
    parameter int DATA_WIDTH = 16,
    parameter int FRAC_BITS  = 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [pac_pkg::CfgIdxW-1:0]  i_cfg_index,
    input  logic [pac_pkg::CfgDataW-1:0] i_cfg_data,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic signed [15:0]           i_measured_angle,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic signed [15:0]           o_drive_output,
    output logic                         o_integral_clamped
);
    import pac_pkg::*;

    t_cfg      cfg;
    t_back_ctl back_ctl;

    logic r_v1;
    logic r_v2;
    logic r_v3;
    logic r_vout;
    logic signed [15:0] r_meas;

    logic rdy1;
    logic rdy2;
    logic rdy3;
    logic rdy_out;
    logic load1;
    logic load2;

    logic signed [DATA_WIDTH-1:0] err;
    logic signed [31:0]           sum;
    logic signed [DATA_WIDTH:0]   delta;

    assign rdy_out = !r_vout || !i_out_stall;
    assign rdy3    = !r_v3 || rdy_out;
    assign rdy2    = !r_v2 || rdy3;
    assign rdy1    = !r_v1 || rdy2;

    assign load1             = i_in_valid && rdy1;
    assign load2             = r_v1 && rdy2;
    assign back_ctl.mul_load = r_v2 && rdy3;
    assign back_ctl.out_load = r_v3 && rdy_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_v3   <= 1'b0;
            r_vout <= 1'b0;
        end else begin
            if (rdy1) begin
                r_v1 <= i_in_valid;
            end
            if (rdy2) begin
                r_v2 <= r_v1;
            end
            if (rdy3) begin
                r_v3 <= r_v2;
            end
            if (rdy_out) begin
                r_vout <= r_v3;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load1) begin
            r_meas <= i_measured_angle;
        end
    end

    pac_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    pac_front #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (load2),
        .i_meas   (r_meas),
        .i_target (cfg.target),
        .o_err    (err),
        .o_sum    (sum),
        .o_delta  (delta)
    );

    pac_back #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_back (
        .i_clk              (i_clk),
        .i_ctl              (back_ctl),
        .i_cfg              (cfg),
        .i_err              (err),
        .i_sum              (sum),
        .i_delta            (delta),
        .o_drive_output     (o_drive_output),
        .o_integral_clamped (o_integral_clamped)
    );

    assign o_in_stall  = !rdy1;
    assign o_out_valid = r_vout;

endmodule

### tb/tb_pid_angle_controller.sv
// Testbench for the PID angle controller: directed and random ticks checked against a predictor.
`timescale 1ns / 1ps
module tb_pid_angle_controller;
    import pac_pkg::*;

    localparam int STUCK_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 6;

    typedef struct {
        logic signed [15:0] drive;
        logic               clamped;
    } t_drive_result;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_cfg_we = 1'b0;
    logic [CfgIdxW-1:0]  i_cfg_index = '0;
    logic [CfgDataW-1:0] i_cfg_data = '0;
    logic                i_in_valid = 1'b0;
    logic                o_in_stall;
    logic signed [15:0]  i_measured_angle = '0;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    logic signed [15:0]  o_drive_output;
    logic                o_integral_clamped;

    pid_angle_controller DUT (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_measured_angle   (i_measured_angle),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_drive_output     (o_drive_output),
        .o_integral_clamped (o_integral_clamped)
    );

    always #1 i_clk = ~i_clk;

    // controller shadow: configuration and loop state
    logic signed [15:0] tgt_angle = '0;
    logic signed [15:0] kp_shadow = '0;
    logic signed [15:0] ki_shadow = '0;
    logic signed [15:0] kd_shadow = '0;
    logic [14:0]        ilim_shadow = IlimReset;
    longint             err_sum_acc = 0;
    logic signed [15:0] prev_err = '0;

    t_drive_result expected_drive_q[$];
    int  fail_count = 0;
    int  stuck_cycles = 0;
    int  burst_left = 0;
    bit  sender_idles = 1'b1;
    bit  receiver_stalls = 1'b1;
    bit  stall_phase = 1'b0;
    int  stall_run_left = 0;

    function automatic longint clip(input longint v, input int w);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (w - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) return hi;
        if (v < lo) return lo;
        return v;
    endfunction

    function automatic t_drive_result predict_tick(input logic signed [15:0] angle);
        longint err;
        longint p_term;
        longint i_term;
        longint d_term;
        longint lim;
        t_drive_result res;
        err = clip(longint'(tgt_angle) - longint'(angle), 16);
        err_sum_acc = clip(err_sum_acc + err, 32);
        lim = ilim_shadow;
        res.clamped = 1'b0;
        p_term = (err * longint'(kp_shadow)) >>> 8;
        i_term = (err_sum_acc * longint'(ki_shadow)) >>> 8;
        if (i_term > lim) begin
            i_term = lim;
            res.clamped = 1'b1;
        end else if (i_term < -lim) begin
            i_term = -lim;
            res.clamped = 1'b1;
        end
        d_term = ((longint'(prev_err) - err) * longint'(kd_shadow)) >>> 8;
        res.drive = 16'(clip(p_term + i_term + d_term, 16));
        prev_err = 16'(err);
        return res;
    endfunction

    task automatic log_failure(input string what);
        fail_count++;
        if (fail_count <= 10) begin
            $display("%s", what);
        end
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_drive_result exp_res;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_drive_q.size() == 0) begin
                log_failure($sformatf("unexpected result beat: drive %0d clamped %0b",
                                      o_drive_output, o_integral_clamped));
            end else begin
                exp_res = expected_drive_q.pop_front();
                if (o_drive_output !== exp_res.drive) begin
                    log_failure($sformatf("drive_output mismatch: expected %0d, got %0d",
                                          exp_res.drive, o_drive_output));
                end
                if (o_integral_clamped !== exp_res.clamped) begin
                    log_failure($sformatf("integral_clamped mismatch: expected %0b, got %0b",
                                          exp_res.clamped, o_integral_clamped));
                end
            end
        end
    end

    // receiver stall pattern
    always @(posedge i_clk) begin
        if (stall_run_left == 0) begin
            stall_phase = ~stall_phase;
            stall_run_left = stall_phase ? $urandom_range(1, 6) : $urandom_range(1, 14);
        end else begin
            stall_run_left--;
        end
        i_out_stall <= receiver_stalls && stall_phase;
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            stuck_cycles = 0;
        end else if (i_in_valid || expected_drive_q.size() != 0) begin
            stuck_cycles++;
        end
        if (stuck_cycles >= STUCK_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic send_angle(input logic signed [15:0] angle);
        int gap;
        i_in_valid <= 1'b1;
        i_measured_angle <= angle;
        do @(posedge i_clk); while (o_in_stall);
        expected_drive_q.push_back(predict_tick(angle));
        if (burst_left > 0) begin
            burst_left--;
        end
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if (sender_idles) begin
                gap = $urandom_range(1, 8);
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task automatic wait_drain();
        i_in_valid <= 1'b0;
        while (expected_drive_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            CfgTarget: tgt_angle = data;
            CfgKp:     kp_shadow = data;
            CfgKi:     ki_shadow = data;
            CfgKd:     kd_shadow = data;
            CfgIlim:   ilim_shadow = data[14:0];
            default: ;
        endcase
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic write_spare_regs();
        for (int idx = int'(CfgIlim) + 1; idx < (1 << CfgIdxW); idx++) begin
            write_reg(idx[CfgIdxW-1:0], 16'($urandom_range(0, 65535)));
        end
    endtask

    function automatic logic [15:0] rand_gain();
        case ($urandom_range(0, 4))
            0: return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
            1: return 16'h0000;
            2: return 16'($urandom_range(0, 65535));
            default: return 16'(int'($urandom_range(0, 1024)) - 512);
        endcase
    endfunction

    function automatic logic [15:0] rand_limit();
        case ($urandom_range(0, 4))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'($urandom_range(0, 65535));
            default: return 16'($urandom_range(0, 600));
        endcase
    endfunction

    task automatic test_reset_values();
        send_angle(16'sh7FFF);
        send_angle(-16'sh8000);
        send_angle(16'sh0000);
        send_angle(-16'sh0001);
    endtask

    task automatic test_error_and_output_saturation();
        wait_drain();
        write_reg(CfgTarget, 16'h7FFF);
        write_reg(CfgKp, 16'h7FFF);
        write_reg(CfgKd, 16'h8000);
        send_angle(-16'sh8000);
        send_angle(16'sh7FFF);
        send_angle(-16'sh8000);
        send_angle(16'sh0000);
        wait_drain();
        write_reg(CfgTarget, 16'h8000);
        write_reg(CfgKp, 16'h8000);
        write_reg(CfgKd, 16'h7FFF);
        send_angle(16'sh7FFF);
        send_angle(-16'sh8000);
        send_angle(16'sh7FFF);
    endtask

    task automatic test_integral_clamp();
        logic signed [15:0] m;
        wait_drain();
        write_reg(CfgTarget, 16'h0000);
        write_reg(CfgKp, 16'h0000);
        write_reg(CfgKd, 16'h0000);
        write_reg(CfgKi, 16'h0100);
        // bring the error sum back to zero
        while (err_sum_acc != 0) begin
            if (err_sum_acc > 32767) m = 16'sh7FFF;
            else if (err_sum_acc < -32767) m = -16'sh7FFF;
            else m = 16'(err_sum_acc);
            send_angle(m);
        end
        wait_drain();
        write_reg(CfgIlim, 16'h8000 | 16'd200);
        send_angle(-16'sd200);
        send_angle(16'sd0);
        wait_drain();
        write_reg(CfgIlim, 16'd199);
        send_angle(16'sd0);
        send_angle(16'sd400);
        wait_drain();
        write_reg(CfgIlim, 16'd0);
        send_angle(16'sd0);
        send_angle(-16'sd200);
        wait_drain();
        write_spare_regs();
        write_reg(CfgIlim, 16'h7FFF);
        send_angle(16'sh7FFF);
        send_angle(16'sd0);
    endtask

    task automatic test_error_sum_swing();
        wait_drain();
        sender_idles = 1'b0;
        receiver_stalls = 1'b0;
        write_reg(CfgKp, 16'h0000);
        write_reg(CfgKd, 16'h0000);
        write_reg(CfgKi, 16'h0001);
        write_reg(CfgIlim, 16'h7FFF);
        write_reg(CfgTarget, 16'h7FFF);
        repeat (20) send_angle(-16'sh8000);
        wait_drain();
        write_reg(CfgTarget, 16'h8000);
        repeat (40) send_angle(16'sh7FFF);
        wait_drain();
        write_reg(CfgTarget, 16'h7FFF);
        repeat (20) send_angle(-16'sh8000);
        sender_idles = 1'b1;
        receiver_stalls = 1'b1;
    endtask

    task automatic test_random_phases();
        int spread;
        longint v;
        logic signed [15:0] m;
        for (int phase = 0; phase < 10; phase++) begin
            wait_drain();
            sender_idles = ($urandom_range(0, 3) != 0);
            receiver_stalls = ($urandom_range(0, 3) != 0);
            write_reg(CfgTarget, $urandom_range(0, 3) == 0 ? rand_gain()
                                                           : 16'($urandom_range(0, 65535)));
            write_reg(CfgKp, rand_gain());
            write_reg(CfgKi, rand_gain());
            write_reg(CfgKd, rand_gain());
            write_reg(CfgIlim, rand_limit());
            if ($urandom_range(0, 3) == 0) begin
                write_spare_regs();
            end
            spread = $urandom_range(0, 1) ? 64 : 4096;
            repeat (115) begin
                case ($urandom_range(0, 9))
                    0: begin
                        case ($urandom_range(0, 3))
                            0: m = -16'sh8000;
                            1: m = 16'sh7FFF;
                            2: m = 16'sh0000;
                            default: m = -16'sh0001;
                        endcase
                    end
                    1, 2, 3: m = 16'($urandom_range(0, 65535));
                    default: begin
                        v = longint'(tgt_angle) + (int'($urandom_range(0, 2 * spread)) - spread);
                        m = 16'(clip(v, 16));
                    end
                endcase
                send_angle(m);
                if ($urandom_range(0, 59) == 0) begin
                    wait_drain();
                end
            end
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_values();
        test_error_and_output_saturation();
        test_integral_clamp();
        test_error_sum_swing();
        test_random_phases();
        wait_drain();
        repeat (10) @(posedge i_clk);
        while (expected_drive_q.size() != 0) begin
            void'(expected_drive_q.pop_front());
            log_failure("expected result never arrived");
        end
        if (fail_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
